>>> design/mtpr_pkg.sv
package mtpr_pkg;

  // Width of the length field and of the turn counter.
  localparam int LEN_W = 8;
  // Width of one stored turn.
  localparam int TURN_W = 2;
  // Width of the read index field.
  localparam int IDX_W = 7;

  // Turn codes.
  localparam logic [TURN_W-1:0] TURN_STRAIGHT = 2'd0;
  localparam logic [TURN_W-1:0] TURN_LEFT     = 2'd1;
  localparam logic [TURN_W-1:0] TURN_RIGHT    = 2'd2;
  localparam logic [TURN_W-1:0] TURN_BACK     = 2'd3;

  // Operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Hand rule settings.
  localparam logic HAND_RIGHT = 1'b0;
  localparam logic HAND_LEFT  = 1'b1;

  // Angles are kept in quarter turns, so adding modulo 360 degrees is a
  // plain 2-bit add that wraps.
  localparam logic [1:0] QTR_0   = 2'd0;
  localparam logic [1:0] QTR_90  = 2'd1;
  localparam logic [1:0] QTR_180 = 2'd2;
  localparam logic [1:0] QTR_270 = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Angle of a turn in quarter turns, mirrored by the hand rule.
  function automatic logic [1:0] turn_quarter(input logic [TURN_W-1:0] t,
                                              input logic hand);
    logic [1:0] q;
    case (t)
      TURN_LEFT:  q = (hand == HAND_LEFT) ? QTR_270 : QTR_90;
      TURN_RIGHT: q = (hand == HAND_LEFT) ? QTR_90 : QTR_270;
      TURN_BACK:  q = QTR_180;
      default:    q = QTR_0;
    endcase
    return q;
  endfunction

  // Turn that corresponds to an angle in quarter turns.
  function automatic logic [TURN_W-1:0] quarter_turn(input logic [1:0] q,
                                                     input logic hand);
    logic [TURN_W-1:0] t;
    case (q)
      QTR_90:  t = (hand == HAND_LEFT) ? TURN_RIGHT : TURN_LEFT;
      QTR_180: t = TURN_BACK;
      QTR_270: t = (hand == HAND_LEFT) ? TURN_LEFT : TURN_RIGHT;
      default: t = TURN_STRAIGHT;
    endcase
    return t;
  endfunction

endpackage

>>> design/mtpr_ram.sv
module mtpr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/maze_turn_path_reducer_top.sv
// A word is accepted in the idle state; its result word is loaded into the
// output register when the execute step goes ahead, and no new word is taken
// before then: an accept step with the memory read and an execute step with
// the write-back; a stalled result holds the execute step and with it the
// input. Reset: rst_n is synchronous and active low; it empties the path and
// selects the right-hand rule. The memory is not cleared.
module maze_turn_path_reducer_top #(
  parameter int PATH_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: op[0], turn[2:1], index[9:3], zero fill.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata fields from bit 0: length[7:0], entry_turn[9:8], reduced[10],
  // overflow[11], zero fill.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);

  import mtpr_pkg::*;

  localparam int AW = $clog2(PATH_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(PATH_DEPTH);

  state_t              state_r, state_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;
  logic                hand_r;
  logic [TURN_W-1:0]   top_r, top_nxt;

  // Operation captured at accept.
  logic                op_r;
  logic [TURN_W-1:0]   turn_r;
  logic                hit_r;
  logic                reduce_r;
  logic                ovf_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]    out_len_r;
  logic [TURN_W-1:0]   out_entry_r;
  logic                out_red_r;
  logic                out_ovf_r;

  // Input field decode.
  logic                in_op;
  logic [TURN_W-1:0]   in_turn;
  logic [IDX_W-1:0]    in_index;
  logic                accept;
  logic                exec_go;
  logic [LEN_W-1:0]    idx_ext;
  logic [LEN_W-1:0]    cnt_m2;
  logic                acc_reduce;
  logic                acc_ovf;
  logic                acc_hit;

  // Memory ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [TURN_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [TURN_W-1:0]   ram_rdata;
  logic [1:0]          qsum;
  logic [TURN_W-1:0]   merged;

  assign in_op    = in_tdata[0];
  assign in_turn  = in_tdata[2:1];
  assign in_index = in_tdata[9:3];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Decisions that need only the counter and the cached top turn.
  assign idx_ext    = {1'b0, in_index};
  assign cnt_m2     = count_r - LEN_W'(2);
  assign acc_ovf    = (in_op == OP_APPEND) && (count_r >= DEPTH_L);
  assign acc_reduce = (in_op == OP_APPEND) && (count_r < DEPTH_L) &&
                      (count_r >= LEN_W'(2)) && (top_r == TURN_BACK);
  assign acc_hit    = (idx_ext < count_r);

  // The second entry from the top is fetched for a merge; a read fetches
  // the requested entry.
  assign ram_re    = accept && ((in_op == OP_READ) || acc_reduce);
  assign ram_raddr = (in_op == OP_READ) ? idx_ext[AW-1:0] : cnt_m2[AW-1:0];

  // Merge of three turns: sum of the quarter-turn angles, wrapping at 360.
  assign qsum   = turn_quarter(turn_r, hand_r) + turn_quarter(top_r, hand_r) +
                  turn_quarter(ram_rdata, hand_r);
  assign merged = quarter_turn(qsum, hand_r);

  // Write-back: the merged turn replaces the second entry from the top, or the
  // new turn is pushed.
  assign ram_we    = exec_go && (op_r == OP_APPEND) && !ovf_r;
  assign ram_waddr = reduce_r ? cnt_m2[AW-1:0] : count_r[AW-1:0];
  assign ram_wdata = reduce_r ? merged : turn_r;

  mtpr_ram #(
    .WIDTH(TURN_W),
    .DEPTH(PATH_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Next state, counter and top-of-path cache.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (ram_we) begin
            if (reduce_r) begin
              count_nxt = count_r - LEN_W'(1);
              top_nxt   = merged;
            end else begin
              count_nxt = count_r + LEN_W'(1);
              top_nxt   = turn_r;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hand_r      <= HAND_RIGHT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        hand_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (accept) begin
      op_r     <= in_op;
      turn_r   <= in_turn;
      hit_r    <= acc_hit;
      reduce_r <= acc_reduce;
      ovf_r    <= acc_ovf;
    end
    if (exec_go) begin
      out_len_r   <= count_nxt;
      out_entry_r <= ((op_r == OP_READ) && hit_r) ? ram_rdata : TURN_STRAIGHT;
      out_red_r   <= reduce_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_ovf_r, out_red_r, out_entry_r, out_len_r};

  // The path never grows past the memory.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_L)
    else $error("turn count exceeds path depth");

  // A merge shortens the path by one net of the push.
  a_merge_len: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && ram_we && reduce_r) |=> (count_r == $past(count_r) - LEN_W'(1)))
    else $error("merge did not shorten the path by one");

  // A dropped turn leaves a full path and is never a merge.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_len_r == DEPTH_L) && !out_red_r)
    else $error("overflow result with wrong length or merge flag");

  // A merge is only decided when the memory was read for it.
  a_merge_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && acc_reduce) |-> ram_re)
    else $error("merge without memory read");

  // A pending result is held until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule
